/* rtl/cpt_pkg.sv */
// Shared constants, types and helpers for the closest-point-on-triangle core.
// Used by every module under rtl; depends on nothing.

package cpt_pkg;

	localparam int CW      = 32;   // coordinate width
	localparam int DW      = CW + 1;   // vertex difference width
	localparam int PRW     = 2 * DW;   // one coordinate product of two differences
	localparam int DOTW    = PRW + 2;  // dot product d1..d6
	localparam int CRW     = 2 * DOTW + 1;  // cross terms va, vb, vc
	localparam int DENW    = CRW + 2;  // face denominator
	localparam int DIG     = 35;   // digit width of the wide multiplier
	localparam int MAW     = 2 * DIG;
	localparam int MBW     = 4 * DIG;
	localparam int MPW     = MAW + MBW;
	localparam int NW      = DW + CRW + 1;  // numerator of one output coordinate
	localparam int QB      = 35;   // quotient bits kept before saturation
	localparam int D2W     = DENW + 1;
	localparam int RW      = D2W + QB + 1;  // divider remainder width
	localparam int MUL_LAT = 4;
	localparam int DIV_LAT = QB + 1;
	localparam int OW      = QB + 2;   // base plus signed quotient
	localparam int IN_W    = 12 * CW;
	localparam int OUT_W   = 3 * CW;

	localparam logic [2:0] RG_VA   = 3'd0;
	localparam logic [2:0] RG_VB   = 3'd1;
	localparam logic [2:0] RG_VC   = 3'd2;
	localparam logic [2:0] RG_AB   = 3'd3;
	localparam logic [2:0] RG_AC   = 3'd4;
	localparam logic [2:0] RG_BC   = 3'd5;
	localparam logic [2:0] RG_FACE = 3'd6;

	// One classified query on its way from the front part to the back part.
	// Each output coordinate is base + round((dir1*w1 + dir2*w2) / den).
	typedef struct packed {
		logic [2:0][CW-1:0] base;
		logic [2:0][DW-1:0] dir1;
		logic [2:0][DW-1:0] dir2;
		logic [CRW-1:0]     w1;
		logic [CRW-1:0]     w2;
		logic [DENW-1:0]    den;
		logic               pt;
		logic [2:0]         region;
		logic               deg;
	} job_t;

	typedef struct packed {
		logic [CW-1:0] base;
		logic [2:0]    region;
		logic          deg;
	} side_t;

	function automatic logic signed [DW-1:0] sx(input logic [CW-1:0] x);
		return {x[CW-1], x};
	endfunction

endpackage

/* rtl/cpt_wmul.sv */
// Four-stage signed multiplier, 70 by 140 bits, built from 35-bit digit products.
// Uses cpt_pkg for widths.

module cpt_wmul (
	input  logic                      clk,
	input  logic                      en,
	input  logic [cpt_pkg::MAW-1:0]   a,
	input  logic [cpt_pkg::MBW-1:0]   b,
	output logic [cpt_pkg::MPW-1:0]   p
);

	localparam int RROW = cpt_pkg::MBW + cpt_pkg::DIG;

	logic [cpt_pkg::MAW-1:0]   am_s1;
	logic [cpt_pkg::MBW-1:0]   bm_s1;
	logic                      neg_s1, neg_s2, neg_s3;
	logic [2*cpt_pkg::DIG-1:0] pp_s2 [2][4];
	logic [RROW-1:0]           row_c [2];
	logic [RROW-1:0]           row_s3 [2];
	logic [cpt_pkg::MPW-1:0]   sum_c;
	logic [cpt_pkg::MPW-1:0]   p_s4;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < 4; j++) begin
				row_c[i] = row_c[i] + (RROW'(pp_s2[i][j]) << (j * cpt_pkg::DIG));
			end
		end
		sum_c = cpt_pkg::MPW'(row_s3[0]) + (cpt_pkg::MPW'(row_s3[1]) << cpt_pkg::DIG);
	end

	// Magnitudes are multiplied and the sign is applied at the end.
	always_ff @(posedge clk) begin
		if (en) begin
			am_s1  <= a[cpt_pkg::MAW-1] ? (~a + 1'b1) : a;
			bm_s1  <= b[cpt_pkg::MBW-1] ? (~b + 1'b1) : b;
			neg_s1 <= a[cpt_pkg::MAW-1] ^ b[cpt_pkg::MBW-1];
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 4; j++) begin
					pp_s2[i][j] <= am_s1[i*cpt_pkg::DIG +: cpt_pkg::DIG]
						* bm_s1[j*cpt_pkg::DIG +: cpt_pkg::DIG];
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			p_s4   <= neg_s3 ? (~sum_c + 1'b1) : sum_c;
		end
	end

	assign p = p_s4;

endmodule

/* rtl/cpt_front.sv */
// Front part: takes queries, forms differences, dot products and cross terms,
// and classifies the Voronoi region. Depends on cpt_pkg and cpt_wmul.

module cpt_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [cpt_pkg::IN_W-1:0]   s_tdata,
	output logic                       push,
	output cpt_pkg::job_t              job,
	input  logic                       full
);

	typedef struct packed {
		logic [2:0][2:0][cpt_pkg::CW-1:0] v;
		logic [2:0][2:0][cpt_pkg::DW-1:0] e;
		logic [5:0][cpt_pkg::DOTW-1:0]    d;
	} carry_t;

	localparam int UIX [6] = '{0, 1, 0, 1, 0, 1};
	localparam int VIX [6] = '{3, 3, 4, 4, 5, 5};
	localparam int MAIX [6] = '{0, 2, 4, 0, 2, 4};
	localparam int MBIX [6] = '{3, 1, 1, 5, 5, 3};

	logic                          en;
	logic [9:1]                    vld_s;
	logic [cpt_pkg::CW-1:0]        vin [4][3];
	logic [cpt_pkg::CW-1:0]        v_s1 [3][3];
	logic [cpt_pkg::CW-1:0]        v_s2 [3][3];
	logic signed [cpt_pkg::DW-1:0] dif_s1 [6][3];
	logic signed [cpt_pkg::DW-1:0] e_s2 [3][3];
	logic signed [cpt_pkg::PRW-1:0] pr_s2 [6][3];
	logic signed [cpt_pkg::DOTW-1:0] dsum_c [6];
	carry_t                        car_s3, car_s4, car_s5, car_s6, car_s7, car_s8;
	logic [cpt_pkg::MAW-1:0]       ma [6];
	logic [cpt_pkg::MBW-1:0]       mb [6];
	logic [cpt_pkg::MPW-1:0]       mp [6];
	logic signed [cpt_pkg::CRW-1:0] va_s8, vb_s8, vc_s8;
	cpt_pkg::job_t                 job_c, job_s9;

	logic signed [cpt_pkg::DOTW-1:0] d1, d2, d3, d4, d5, d6;
	logic signed [cpt_pkg::DOTW:0]   d43, d56, den_ab, den_ac;
	logic signed [cpt_pkg::DOTW+1:0] den_bc;
	logic signed [cpt_pkg::DENW-1:0] den_f;

	assign en       = !vld_s[9] || !full;
	assign s_tready = en;
	assign push     = vld_s[9] && !full;
	assign job      = job_s9;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 3; j++) begin
				vin[i][j] = s_tdata[(i*3+j)*cpt_pkg::CW +: cpt_pkg::CW];
			end
		end
		for (int k = 0; k < 6; k++) begin
			dsum_c[k] = pr_s2[k][0] + pr_s2[k][1] + pr_s2[k][2];
		end
		for (int m = 0; m < 6; m++) begin
			ma[m] = {{(cpt_pkg::MAW-cpt_pkg::DOTW){car_s3.d[MAIX[m]][cpt_pkg::DOTW-1]}},
				car_s3.d[MAIX[m]]};
			mb[m] = {{(cpt_pkg::MBW-cpt_pkg::DOTW){car_s3.d[MBIX[m]][cpt_pkg::DOTW-1]}},
				car_s3.d[MBIX[m]]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[8:1], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					v_s1[i][j] <= vin[i][j];
					v_s2[i][j] <= v_s1[i][j];
					e_s2[i][j] <= dif_s1[i][j];
				end
				dif_s1[0][j] <= cpt_pkg::sx(vin[1][j]) - cpt_pkg::sx(vin[0][j]);
				dif_s1[1][j] <= cpt_pkg::sx(vin[2][j]) - cpt_pkg::sx(vin[0][j]);
				dif_s1[2][j] <= cpt_pkg::sx(vin[2][j]) - cpt_pkg::sx(vin[1][j]);
				dif_s1[3][j] <= cpt_pkg::sx(vin[3][j]) - cpt_pkg::sx(vin[0][j]);
				dif_s1[4][j] <= cpt_pkg::sx(vin[3][j]) - cpt_pkg::sx(vin[1][j]);
				dif_s1[5][j] <= cpt_pkg::sx(vin[3][j]) - cpt_pkg::sx(vin[2][j]);
				for (int k = 0; k < 6; k++) begin
					pr_s2[k][j] <= dif_s1[UIX[k]][j] * dif_s1[VIX[k]][j];
				end
				for (int i = 0; i < 3; i++) begin
					car_s3.v[i][j] <= v_s2[i][j];
					car_s3.e[i][j] <= e_s2[i][j];
				end
			end
			for (int k = 0; k < 6; k++) begin
				car_s3.d[k] <= dsum_c[k];
			end
			car_s4 <= car_s3;
			car_s5 <= car_s4;
			car_s6 <= car_s5;
			car_s7 <= car_s6;
			car_s8 <= car_s7;
			vc_s8  <= $signed(mp[0][cpt_pkg::CRW-1:0]) - $signed(mp[1][cpt_pkg::CRW-1:0]);
			vb_s8  <= $signed(mp[2][cpt_pkg::CRW-1:0]) - $signed(mp[3][cpt_pkg::CRW-1:0]);
			va_s8  <= $signed(mp[4][cpt_pkg::CRW-1:0]) - $signed(mp[5][cpt_pkg::CRW-1:0]);
			job_s9 <= job_c;
		end
	end

	for (genvar m = 0; m < 6; m++) begin : g_mul
		cpt_wmul u_mul (
			.clk (clk),
			.en  (en),
			.a   (ma[m]),
			.b   (mb[m]),
			.p   (mp[m])
		);
	end

	assign d1     = car_s8.d[0];
	assign d2     = car_s8.d[1];
	assign d3     = car_s8.d[2];
	assign d4     = car_s8.d[3];
	assign d5     = car_s8.d[4];
	assign d6     = car_s8.d[5];
	assign d43    = d4 - d3;
	assign d56    = d5 - d6;
	assign den_ab = d1 - d3;
	assign den_ac = d2 - d6;
	assign den_bc = d43 + d56;
	assign den_f  = va_s8 + vb_s8 + vc_s8;

	// Region tests in priority order; the first match wins.
	always_comb begin
		job_c        = '0;
		job_c.base   = car_s8.v[0];
		job_c.dir1   = car_s8.e[0];
		job_c.dir2   = car_s8.e[1];
		job_c.pt     = 1'b1;
		job_c.region = cpt_pkg::RG_VA;
		if (d1 <= 0 && d2 <= 0) begin
			job_c.region = cpt_pkg::RG_VA;
		end else if (d3 >= 0 && d43 <= 0) begin
			job_c.base   = car_s8.v[1];
			job_c.region = cpt_pkg::RG_VB;
		end else if (d6 >= 0 && d56 <= 0) begin
			job_c.base   = car_s8.v[2];
			job_c.region = cpt_pkg::RG_VC;
		end else if (vc_s8 <= 0 && d1 >= 0 && d3 <= 0) begin
			job_c.pt     = 1'b0;
			job_c.region = cpt_pkg::RG_AB;
			job_c.w1     = cpt_pkg::CRW'(d1);
			job_c.den    = cpt_pkg::DENW'(den_ab);
		end else if (vb_s8 <= 0 && d2 >= 0 && d6 <= 0) begin
			job_c.pt     = 1'b0;
			job_c.region = cpt_pkg::RG_AC;
			job_c.dir1   = car_s8.e[1];
			job_c.w1     = cpt_pkg::CRW'(d2);
			job_c.den    = cpt_pkg::DENW'(den_ac);
		end else if (va_s8 <= 0 && d43 >= 0 && d56 >= 0) begin
			job_c.pt     = 1'b0;
			job_c.region = cpt_pkg::RG_BC;
			job_c.base   = car_s8.v[1];
			job_c.dir1   = car_s8.e[2];
			job_c.w1     = cpt_pkg::CRW'(d43);
			job_c.den    = cpt_pkg::DENW'(den_bc);
		end else if (den_f == 0) begin
			job_c.region = cpt_pkg::RG_FACE;
			job_c.deg    = 1'b1;
		end else begin
			job_c.pt     = 1'b0;
			job_c.region = cpt_pkg::RG_FACE;
			job_c.w1     = vb_s8;
			job_c.w2     = vc_s8;
			job_c.den    = den_f;
		end
	end

endmodule

/* rtl/cpt_fifo.sv */
// Four-entry queue of classified queries between the front and back parts.
// Uses cpt_pkg::job_t.

module cpt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cpt_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output cpt_pkg::job_t dout,
	output logic          nonempty
);

	cpt_pkg::job_t mem_q [4];
	logic [1:0]    wr_ptr_q, rd_ptr_q;
	logic [2:0]    cnt_q;

	assign full     = (cnt_q == 3'd4);
	assign nonempty = (cnt_q != 3'd0);
	assign dout     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

endmodule

/* rtl/cpt_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// check up front. Carries cpt_pkg::side_t alongside the quotient.

module cpt_div (
	input  logic                    clk,
	input  logic                    en,
	input  logic [cpt_pkg::RW-1:0]  nn,
	input  logic [cpt_pkg::D2W-1:0] d2,
	input  logic                    neg,
	input  cpt_pkg::side_t          side,
	output logic [cpt_pkg::QB-1:0]  q,
	output logic                    ovf,
	output logic                    neg_o,
	output cpt_pkg::side_t          side_o
);

	logic [cpt_pkg::RW-1:0]  r_s  [cpt_pkg::QB+1];
	logic [cpt_pkg::D2W-1:0] d_s  [cpt_pkg::QB+1];
	logic [cpt_pkg::QB-1:0]  q_s  [cpt_pkg::QB+1];
	logic                    ov_s [cpt_pkg::QB+1];
	logic                    ng_s [cpt_pkg::QB+1];
	cpt_pkg::side_t          sd_s [cpt_pkg::QB+1];

	// A quotient that does not fit in QB bits saturates the result anyway.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]  <= nn;
			d_s[0]  <= d2;
			q_s[0]  <= '0;
			ov_s[0] <= nn >= (cpt_pkg::RW'(d2) << cpt_pkg::QB);
			ng_s[0] <= neg;
			sd_s[0] <= side;
		end
	end

	for (genvar g = 0; g < cpt_pkg::QB; g++) begin : g_stage
		localparam int K = cpt_pkg::QB - 1 - g;
		logic [cpt_pkg::RW-1:0] sh;
		logic                   ge;
		assign sh = cpt_pkg::RW'(d_s[g]) << K;
		assign ge = r_s[g] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g+1]  <= ge ? (r_s[g] - sh) : r_s[g];
				q_s[g+1]  <= q_s[g] | (cpt_pkg::QB'(ge) << K);
				d_s[g+1]  <= d_s[g];
				ov_s[g+1] <= ov_s[g];
				ng_s[g+1] <= ng_s[g];
				sd_s[g+1] <= sd_s[g];
			end
		end
	end

	assign q      = q_s[cpt_pkg::QB];
	assign ovf    = ov_s[cpt_pkg::QB];
	assign neg_o  = ng_s[cpt_pkg::QB];
	assign side_o = sd_s[cpt_pkg::QB];

endmodule

/* rtl/cpt_back.sv */
// Back part: numerator products, rounded divide per coordinate, saturation and
// the output register. Depends on cpt_pkg, cpt_wmul and cpt_div.

module cpt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  cpt_pkg::job_t               job,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [cpt_pkg::OUT_W-1:0]   m_tdata,
	output logic [3:0]                  m_tuser
);

	localparam int BL = cpt_pkg::MUL_LAT + 1 + cpt_pkg::DIV_LAT;
	localparam logic signed [cpt_pkg::OW-1:0] SMAX = (cpt_pkg::OW'(1) << (cpt_pkg::CW-1)) - 1;
	localparam logic signed [cpt_pkg::OW-1:0] SMIN = -(cpt_pkg::OW'(1) << (cpt_pkg::CW-1));

	typedef struct packed {
		logic [2:0][cpt_pkg::CW-1:0] base;
		logic [cpt_pkg::DENW-1:0]    den;
		logic                        pt;
		logic [2:0]                  region;
		logic                        deg;
	} bk_t;

	logic                     en;
	logic [BL:1]              vld_s;
	logic                     vld_q;
	bk_t                      bk_c, bk_s1, bk_s2, bk_s3, bk_s4;
	logic [cpt_pkg::MAW-1:0]  ma [6];
	logic [cpt_pkg::MBW-1:0]  mb [6];
	logic [cpt_pkg::MPW-1:0]  mp [6];
	logic [cpt_pkg::RW-1:0]   nn_s5 [3];
	logic [cpt_pkg::D2W-1:0]  d2_s5 [3];
	logic                     neg_s5 [3];
	cpt_pkg::side_t           side_s5 [3];
	logic [cpt_pkg::QB-1:0]   dq [3];
	logic                     dovf [3];
	logic                     dneg [3];
	cpt_pkg::side_t           dside [3];
	logic [cpt_pkg::CW-1:0]   q_q [3];
	logic [3:0]               user_q;
	logic signed [cpt_pkg::DENW-1:0] den_c;
	logic [cpt_pkg::DENW-1:0] absd_c;

	assign en       = !vld_q || m_tready;
	assign pop      = en && job_valid;
	assign m_tvalid = vld_q;
	assign m_tdata  = {q_q[2], q_q[1], q_q[0]};
	assign m_tuser  = user_q;

	always_comb begin
		bk_c.base   = job.base;
		bk_c.den    = job.den;
		bk_c.pt     = job.pt;
		bk_c.region = job.region;
		bk_c.deg    = job.deg;
		for (int j = 0; j < 3; j++) begin
			ma[j]   = {{(cpt_pkg::MAW-cpt_pkg::DW){job.dir1[j][cpt_pkg::DW-1]}}, job.dir1[j]};
			mb[j]   = {{(cpt_pkg::MBW-cpt_pkg::CRW){job.w1[cpt_pkg::CRW-1]}}, job.w1};
			ma[j+3] = {{(cpt_pkg::MAW-cpt_pkg::DW){job.dir2[j][cpt_pkg::DW-1]}}, job.dir2[j]};
			mb[j+3] = {{(cpt_pkg::MBW-cpt_pkg::CRW){job.w2[cpt_pkg::CRW-1]}}, job.w2};
		end
	end

	for (genvar m = 0; m < 6; m++) begin : g_mul
		cpt_wmul u_mul (
			.clk (clk),
			.en  (en),
			.a   (ma[m]),
			.b   (mb[m]),
			.p   (mp[m])
		);
	end

	assign den_c  = bk_s4.den;
	assign absd_c = den_c[cpt_pkg::DENW-1] ? (~bk_s4.den + 1'b1) : bk_s4.den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[BL-1:1], job_valid};
			vld_q <= vld_s[BL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s1 <= bk_c;
			bk_s2 <= bk_s1;
			bk_s3 <= bk_s2;
			bk_s4 <= bk_s3;
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_lane
		logic signed [cpt_pkg::NW-1:0] num;
		logic [cpt_pkg::NW-1:0]        absn;
		logic signed [cpt_pkg::OW-1:0] qs, sum;

		assign num  = $signed(mp[j][cpt_pkg::NW-1:0]) + $signed(mp[j+3][cpt_pkg::NW-1:0]);
		assign absn = num[cpt_pkg::NW-1] ? (~num + 1'b1) : num;

		// Point results and empty edges divide zero by one, leaving the base.
		always_ff @(posedge clk) begin
			if (en) begin
				if (bk_s4.pt || den_c == 0) begin
					nn_s5[j] <= '0;
					d2_s5[j] <= cpt_pkg::D2W'(1);
				end else begin
					nn_s5[j] <= (cpt_pkg::RW'(absn) << 1) + cpt_pkg::RW'(absd_c);
					d2_s5[j] <= {absd_c, 1'b0};
				end
				neg_s5[j]         <= num[cpt_pkg::NW-1] ^ den_c[cpt_pkg::DENW-1];
				side_s5[j].base   <= bk_s4.base[j];
				side_s5[j].region <= bk_s4.region;
				side_s5[j].deg    <= bk_s4.deg;
			end
		end

		cpt_div u_div (
			.clk    (clk),
			.en     (en),
			.nn     (nn_s5[j]),
			.d2     (d2_s5[j]),
			.neg    (neg_s5[j]),
			.side   (side_s5[j]),
			.q      (dq[j]),
			.ovf    (dovf[j]),
			.neg_o  (dneg[j]),
			.side_o (dside[j])
		);

		assign qs  = dneg[j] ? -$signed({2'b00, dq[j]}) : $signed({2'b00, dq[j]});
		assign sum = $signed({{(cpt_pkg::OW-cpt_pkg::CW){dside[j].base[cpt_pkg::CW-1]}},
			dside[j].base}) + qs;

		always_ff @(posedge clk) begin
			if (en) begin
				if (dovf[j]) begin
					q_q[j] <= dneg[j] ? SMIN[cpt_pkg::CW-1:0] : SMAX[cpt_pkg::CW-1:0];
				end else if (sum > SMAX) begin
					q_q[j] <= SMAX[cpt_pkg::CW-1:0];
				end else if (sum < SMIN) begin
					q_q[j] <= SMIN[cpt_pkg::CW-1:0];
				end else begin
					q_q[j] <= sum[cpt_pkg::CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			user_q <= {dside[0].deg, dside[0].region};
		end
	end

endmodule

/* rtl/closest_point_on_triangle_core.sv */
// Top level of the closest-point-on-triangle core: front part, queue, back part.
// Depends on cpt_pkg, cpt_front, cpt_fifo and cpt_back.
//
// The core takes one triangle and query point per cycle while s_tready is high
// and returns, per transaction, the nearest point of the triangle with its
// Voronoi region code and a degenerate-face flag. Throughput is one transaction
// per clock when the output side is ready. A query passes through the front
// part (differences, dot products, a 4-stage wide multiplier for the cross
// terms, classification), the queue, and the back part (4-stage numerator
// multiplier, operand setup, a 36-stage divider with an overflow check and then
// one quotient bit per stage, output register). A four-entry queue lets the
// front keep accepting while the output is stalled.

module closest_point_on_triangle_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z (32 bits each)
	input  logic [cpt_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// q_x, q_y, q_z (32 bits each)
	output logic [cpt_pkg::OUT_W-1:0] m_tdata,
	// region (3 bits), degenerate (1 bit)
	output logic [3:0]                m_tuser
);

	logic          push, full, pop, nonempty;
	cpt_pkg::job_t job_in, job_out;

	cpt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.job      (job_in),
		.full     (full)
	);

	cpt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (job_in),
		.full     (full),
		.pop      (pop),
		.dout     (job_out),
		.nonempty (nonempty)
	);

	cpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (nonempty),
		.job       (job_out),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* rtl/cpt_chk.sv */
// Port-level checker for the closest-point-on-triangle core, bound to the top.
// Depends on cpt_pkg for port widths and region codes.

module cpt_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [cpt_pkg::OUT_W-1:0] m_tdata,
	input logic [3:0]                m_tuser
);

	// A result waiting on the output side stays until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Only the face region can report a degenerate denominator.
	a_deg_face: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tuser[2:0] == cpt_pkg::RG_FACE)
		else $error("degenerate flag outside face region");

	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:0] <= cpt_pkg::RG_FACE)
		else $error("undefined region code");

endmodule

bind closest_point_on_triangle_core cpt_chk u_chk (.*);
